// ===== design/bss_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the bounded substring search block
// no dependencies

package bss_pkg;

	localparam int NEEDLE_REG_BYTES  = 16;
	localparam int NIDX_W            = $clog2(NEEDLE_REG_BYTES);
	localparam int LEN_W             = 5;
	localparam int LIMIT_W           = 32;
	localparam int CFG_DATA_W        = 64;
	localparam int CFG_INDEX_W       = 3;
	localparam int MATCH_POS_W       = 32;
	localparam int MAX_NEEDLE_DEF    = 16;
	localparam int POSITION_BITS_DEF = 32;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_NEEDLE_LOW  = 3'd0,
		CFG_NEEDLE_HIGH = 3'd1,
		CFG_NEEDLE_LEN  = 3'd2,
		CFG_LIMIT       = 3'd3
	} cfg_reg_t;

	typedef logic [NEEDLE_REG_BYTES-1:0][7:0] needle_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

endpackage

// ===== design/bss_needle.sv =====
`timescale 1ns / 1ps
// effective needle length from the needle registers, length and limit
// depends on bss_pkg

module bss_needle import bss_pkg::*; #(
	parameter int MAX_NEEDLE = MAX_NEEDLE_DEF
) (
	input  logic [CFG_DATA_W-1:0] needle_low,
	input  logic [CFG_DATA_W-1:0] needle_high,
	input  logic [LEN_W-1:0]      needle_length,
	input  logic [LIMIT_W-1:0]    search_limit,
	output needle_t               needle,
	output logic [LEN_W-1:0]      nn
);

	localparam int NEEDLE_CAP = (MAX_NEEDLE < NEEDLE_REG_BYTES) ? MAX_NEEDLE : NEEDLE_REG_BYTES;
	localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(NEEDLE_CAP);

	logic [LEN_W-1:0] capped;
	logic [LEN_W-1:0] trimmed;

	assign needle = {needle_high, needle_low};

	always_comb begin
		capped = (needle_length > CAP_LEN) ? CAP_LEN : needle_length;
		trimmed = capped;
		// lowest zero byte inside the length ends the needle
		for (int i = NEEDLE_CAP - 1; i >= 0; i--) begin
			if (needle[i] == 8'd0 && LEN_W'(i) < capped) begin
				trimmed = LEN_W'(i);
			end
		end
		if (LIMIT_W'(trimmed) > search_limit) begin
			nn = search_limit[LEN_W-1:0];
		end else begin
			nn = trimmed;
		end
	end

endmodule

// ===== design/bss_cell.sv =====
`timescale 1ns / 1ps
// one window cell: holds a recent haystack byte and compares it to its needle byte
// depends on bss_pkg

module bss_cell import bss_pkg::*; #(
	parameter int CELL_IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  logic [7:0]       byte_in,
	input  needle_t          needle,
	input  logic [LEN_W-1:0] nn,
	output logic [7:0]       byte_out,
	output logic             eq
);

	logic [7:0]        byte_q;
	logic              active;
	logic [NIDX_W-1:0] sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctl.clear) begin
			byte_q <= '0;
		end else if (ctl.shift) begin
			byte_q <= byte_in;
		end
	end

	// cell k lines up with needle byte nn-1-k once the new byte is in
	assign active = int'(nn) > CELL_IDX;
	assign sel = NIDX_W'(int'(nn) - 1 - CELL_IDX);
	assign eq = !active || (byte_in == needle[sel]);
	assign byte_out = byte_q;

endmodule

// ===== design/bounded_substring_search.sv =====
`timescale 1ns / 1ps
// top level of the bounded substring search: config registers, cell row, result register
// depends on bss_pkg, bss_needle, bss_cell

// Takes one haystack byte per clock unless stalled; the result of a byte sits in the
// output register in the cycle after its beat and is held there until taken. The byte
// rate is set by the row of window cells, which compare every needle position in
// parallel each cycle. haystack_stall rises only while a result is held by result_stall.
// A string ends with a zero byte, which yields a miss (hit for empty needle) if nothing
// was reported and clears the window, the position counter and the answered flag.
// cfg_ready is always high; writes to indexes beyond the four registers are dropped.
module bounded_substring_search import bss_pkg::*; #(
	parameter int MAX_NEEDLE    = MAX_NEEDLE_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   haystack_valid,
	output logic                   haystack_stall,
	input  logic [7:0]             haystack_byte,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic                   found,
	output logic [MATCH_POS_W-1:0] match_position
);

	localparam int WB = ((POSITION_BITS > LIMIT_W) ? POSITION_BITS : LIMIT_W) + 1;

	logic [CFG_DATA_W-1:0]  needle_low_q;
	logic [CFG_DATA_W-1:0]  needle_high_q;
	logic [LEN_W-1:0]       needle_len_q;
	logic [LIMIT_W-1:0]     search_limit_q;

	logic [POSITION_BITS-1:0] position_q;
	logic [POSITION_BITS-1:0] position_next;
	logic                     answered_q;
	logic                     answered_next;

	logic                   result_valid_q;
	logic                   found_q;
	logic [MATCH_POS_W-1:0] match_position_q;

	needle_t          needle;
	logic [LEN_W-1:0] nn;
	cell_ctl_t        ctl;
	logic [7:0]       window [MAX_NEEDLE];
	logic [MAX_NEEDLE-1:0] eq;

	logic                   accept;
	logic                   emit;
	logic                   emit_found;
	logic [MATCH_POS_W-1:0] emit_pos;
	logic [WB-1:0]          start;
	logic                   reach;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_low_q   <= '0;
			needle_high_q  <= '0;
			needle_len_q   <= '0;
			search_limit_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_NEEDLE_LOW:  needle_low_q   <= cfg_data;
				CFG_NEEDLE_HIGH: needle_high_q  <= cfg_data;
				CFG_NEEDLE_LEN:  needle_len_q   <= cfg_data[LEN_W-1:0];
				CFG_LIMIT:       search_limit_q <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	bss_needle #(
		.MAX_NEEDLE(MAX_NEEDLE)
	) u_needle (
		.needle_low   (needle_low_q),
		.needle_high  (needle_high_q),
		.needle_length(needle_len_q),
		.search_limit (search_limit_q),
		.needle       (needle),
		.nn           (nn)
	);

	// window cell row, newest byte in cell 0
	for (genvar k = 0; k < MAX_NEEDLE; k++) begin : g_cell
		logic [7:0] cell_in;
		if (k == 0) begin : g_head
			assign cell_in = haystack_byte;
		end else begin : g_link
			assign cell_in = window[k-1];
		end
		bss_cell #(
			.CELL_IDX(k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.byte_in (cell_in),
			.needle  (needle),
			.nn      (nn),
			.byte_out(window[k]),
			.eq      (eq[k])
		);
	end

	assign haystack_stall = result_valid_q && result_stall;
	assign accept = haystack_valid && !haystack_stall;

	assign start = WB'(position_q) + WB'(1) - WB'(nn);
	assign reach = (WB'(position_q) + WB'(1)) >= WB'(nn);

	always_comb begin
		emit          = 1'b0;
		emit_found    = 1'b0;
		emit_pos      = '0;
		ctl           = '0;
		position_next = position_q;
		answered_next = answered_q;
		if (accept) begin
			if (haystack_byte == 8'd0) begin
				emit          = !answered_q;
				emit_found    = (nn == '0);
				ctl.clear     = 1'b1;
				position_next = '0;
				answered_next = 1'b0;
			end else if (!answered_q) begin
				if (nn == '0) begin
					emit          = 1'b1;
					emit_found    = 1'b1;
					answered_next = 1'b1;
				end else begin
					ctl.shift = 1'b1;
					// a saturated counter still shifts but checks nothing
					if (position_q != '1) begin
						position_next = position_q + POSITION_BITS'(1);
						if (reach && start < WB'(search_limit_q) && (&eq)) begin
							emit          = 1'b1;
							emit_found    = 1'b1;
							emit_pos      = start[MATCH_POS_W-1:0];
							answered_next = 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			answered_q <= 1'b0;
		end else begin
			position_q <= position_next;
			answered_q <= answered_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			found_q          <= emit_found;
			match_position_q <= emit_pos;
		end
	end

	assign result_valid   = result_valid_q;
	assign found          = found_q;
	assign match_position = match_position_q;

`ifndef SYNTH
	a_miss_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !found |-> match_position == '0)
		else $error("miss beat with nonzero position");

	a_nul_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && haystack_byte == 8'd0 |=> position_q == '0 && !answered_q)
		else $error("string end did not clear state");

	a_answered_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && haystack_byte != 8'd0 && answered_q |=> $stable(position_q) && answered_q)
		else $error("state moved after a result");

	a_hit_sets_answered: assert property (@(posedge clk) disable iff (!arst_n)
		emit && haystack_byte != 8'd0 |=> answered_q && result_valid)
		else $error("hit not recorded");
`endif

endmodule
